// ===== rtl/pnmd_pkg.sv =====
// Shared types and constants for the PNM stream decoder.
// Used by pnmd_parser, pnm_stream_decoder and pnmd_checker; depends on nothing.
`default_nettype none

package pnmd_pkg;

  localparam int unsigned DimBits = 16;
  localparam int unsigned TokBits = DimBits + 1;
  localparam int unsigned ProdBits = TokBits + 4;
  localparam logic [TokBits-1:0] TokMax = {TokBits{1'b1}};

  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChOne  = 8'h31;
  localparam logic [7:0] ChTwo  = 8'h32;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChFour = 8'h34;
  localparam logic [7:0] ChFive = 8'h35;
  localparam logic [7:0] ChSix  = 8'h36;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChUpP  = 8'h50;
  localparam logic [7:0] ChLowP = 8'h70;
  localparam logic [7:0] MaxSample = 8'hff;

  // Bit positions of the result fields inside m_axis_tdata
  localparam int unsigned ErrLsb = 89;
  localparam int unsigned DataBits = 96;

  typedef enum logic [1:0] {
    KindPixel  = 2'd0,
    KindHeader = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone   = 3'd0,
    ErrMagic  = 3'd1,
    ErrBitmap = 3'd2,
    ErrMaxval = 3'd3,
    ErrSize   = 3'd4,
    ErrTrunc  = 3'd5
  } err_e;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [DimBits-1:0]  x;
    logic [DimBits-1:0]  y;
    logic [DimBits-1:0]  width;
    logic [DimBits-1:0]  height;
    logic                is_color;
    err_e                err;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/pnmd_parser.sv =====
// Per-byte PNM parse step: header tokens, samples, pixel counters and errors.
// Holds the parse state; depends on pnmd_pkg.
`default_nettype none

module pnmd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          end_i,
  output logic               res_vld_o,
  output pnmd_pkg::res_t     res_o
);

  typedef enum logic [2:0] {
    PhMagic    = 3'd0,
    PhWidth    = 3'd1,
    PhHeight   = 3'd2,
    PhMaxval   = 3'd3,
    PhSamples  = 3'd4,
    PhFinished = 3'd5
  } phase_e;

  localparam int unsigned DB = pnmd_pkg::DimBits;
  localparam int unsigned TB = pnmd_pkg::TokBits;
  localparam int unsigned PB = pnmd_pkg::ProdBits;

  phase_e            phase_q, phase_d;
  logic [TB-1:0]     tok_q, tok_d;
  logic              started_q, started_d;
  logic [7:0]        magic_q, magic_d;
  logic              cmt_q, cmt_d;
  logic              raw_q, raw_d;
  logic              color_q, color_d;
  logic [DB-1:0]     width_q, width_d;
  logic [DB-1:0]     height_q, height_d;
  logic [DB-1:0]     col_q, col_d;
  logic [DB-1:0]     row_q, row_d;
  logic [1:0]        chan_q, chan_d;
  logic [15:0]       held_q, held_d;

  logic              do_finish;
  logic              do_sample;
  logic [7:0]        smp;
  logic [PB-1:0]     prod;
  logic [TB-1:0]     fin_v;
  logic [DB:0]       col_inc;
  logic [DB:0]       row_inc;
  logic              is_last;
  logic              magic_ok;

  assign prod = ({{(PB-TB){1'b0}}, tok_q} << 3) + ({{(PB-TB){1'b0}}, tok_q} << 1)
              + {{(PB-4){1'b0}}, byte_i[3:0]};
  assign col_inc = {1'b0, col_q} + {{DB{1'b0}}, 1'b1};
  assign row_inc = {1'b0, row_q} + {{DB{1'b0}}, 1'b1};
  assign is_last = (col_inc >= {1'b0, width_q}) && (row_inc >= {1'b0, height_q});

  always_comb begin
    phase_d   = phase_q;
    tok_d     = tok_q;
    started_d = started_q;
    magic_d   = magic_q;
    cmt_d     = cmt_q;
    raw_d     = raw_q;
    color_d   = color_q;
    width_d   = width_q;
    height_d  = height_q;
    col_d     = col_q;
    row_d     = row_q;
    chan_d    = chan_q;
    held_d    = held_q;
    do_finish = 1'b0;
    do_sample = 1'b0;
    smp       = byte_i;
    fin_v     = '0;
    magic_ok  = 1'b0;
    res_vld_o = 1'b0;
    res_o     = '0;
    res_o.kind = pnmd_pkg::KindPixel;
    res_o.err  = pnmd_pkg::ErrNone;

    // Byte path
    if (phase_q != PhFinished) begin
      if (phase_q == PhSamples && raw_q) begin
        do_sample = 1'b1;
      end else if (cmt_q) begin
        if (byte_i == pnmd_pkg::ChLf) begin
          cmt_d     = 1'b0;
          do_finish = started_q;
        end
      end else if (byte_i == pnmd_pkg::ChHash) begin
        cmt_d = 1'b1;
      end else if (byte_i == pnmd_pkg::ChCr) begin
        cmt_d = cmt_q;
      end else if (byte_i == pnmd_pkg::ChSp || byte_i == pnmd_pkg::ChLf) begin
        do_finish = started_q;
      end else begin
        started_d = 1'b1;
        if (phase_q == PhMagic) begin
          if (tok_q == '0) begin
            magic_d = byte_i;
          end else if (tok_q == {{(TB-1){1'b0}}, 1'b1}) begin
            magic_d = (magic_q == pnmd_pkg::ChUpP || magic_q == pnmd_pkg::ChLowP) ?
                      byte_i : 8'h00;
          end
          if (tok_q < TB'(3)) begin
            tok_d = tok_q + {{(TB-1){1'b0}}, 1'b1};
          end
        end else if (byte_i >= pnmd_pkg::ChZero && byte_i <= pnmd_pkg::ChNine) begin
          if (phase_q == PhSamples) begin
            tok_d = prod[TB-1:0];
          end else begin
            tok_d = (prod > {{(PB-TB){1'b0}}, pnmd_pkg::TokMax}) ?
                    pnmd_pkg::TokMax : prod[TB-1:0];
          end
        end
      end
    end

    // Close an open token on the final byte
    if (end_i && phase_q != PhFinished && started_d) begin
      do_finish = 1'b1;
    end

    if (do_finish) begin
      fin_v     = tok_d;
      tok_d     = '0;
      started_d = 1'b0;
      case (phase_q)
        PhMagic: begin
          magic_ok = (magic_d == pnmd_pkg::ChTwo) || (magic_d == pnmd_pkg::ChThree) ||
                     (magic_d == pnmd_pkg::ChFive) || (magic_d == pnmd_pkg::ChSix);
          if (fin_v == TB'(2) && magic_ok) begin
            raw_d   = (magic_d == pnmd_pkg::ChFive) || (magic_d == pnmd_pkg::ChSix);
            color_d = (magic_d == pnmd_pkg::ChThree) || (magic_d == pnmd_pkg::ChSix);
            phase_d = PhWidth;
          end else if (fin_v == TB'(2) &&
                       (magic_d == pnmd_pkg::ChOne || magic_d == pnmd_pkg::ChFour)) begin
            res_vld_o  = 1'b1;
            res_o.kind = pnmd_pkg::KindError;
            res_o.err  = pnmd_pkg::ErrBitmap;
            phase_d    = PhFinished;
          end else begin
            res_vld_o  = 1'b1;
            res_o.kind = pnmd_pkg::KindError;
            res_o.err  = pnmd_pkg::ErrMagic;
            phase_d    = PhFinished;
          end
        end
        PhWidth: begin
          width_d = fin_v[TB-1] ? '0 : fin_v[DB-1:0];
          phase_d = PhHeight;
        end
        PhHeight: begin
          height_d = fin_v[TB-1] ? '0 : fin_v[DB-1:0];
          phase_d  = PhMaxval;
        end
        PhMaxval: begin
          res_vld_o = 1'b1;
          if (fin_v == '0 || fin_v > {{(TB-8){1'b0}}, pnmd_pkg::MaxSample}) begin
            res_o.kind = pnmd_pkg::KindError;
            res_o.err  = pnmd_pkg::ErrMaxval;
            phase_d    = PhFinished;
          end else if (width_q == '0 || height_q == '0) begin
            res_o.kind = pnmd_pkg::KindError;
            res_o.err  = pnmd_pkg::ErrSize;
            phase_d    = PhFinished;
          end else begin
            res_o.kind = pnmd_pkg::KindHeader;
            col_d      = '0;
            row_d      = '0;
            chan_d     = '0;
            held_d     = '0;
            phase_d    = PhSamples;
          end
        end
        PhSamples: begin
          do_sample = 1'b1;
          smp       = fin_v[7:0];
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    if (do_sample) begin
      if (color_q && chan_q < 2'd2) begin
        held_d = {held_q[7:0], smp};
        chan_d = chan_q + 2'd1;
      end else begin
        res_vld_o = 1'b1;
        res_o.kind = pnmd_pkg::KindPixel;
        if (color_q) begin
          res_o.red   = held_q[15:8];
          res_o.green = held_q[7:0];
        end else begin
          res_o.red   = smp;
          res_o.green = smp;
        end
        res_o.blue = smp;
        res_o.x    = col_q;
        res_o.y    = row_q;
        res_o.last = is_last;
        chan_d     = '0;
        held_d     = '0;
        if (col_inc >= {1'b0, width_q}) begin
          col_d = '0;
          row_d = row_inc[DB-1:0];
        end else begin
          col_d = col_inc[DB-1:0];
        end
        if (is_last) begin
          phase_d = PhFinished;
        end
      end
    end

    // Truncated file replaces any other result of the final byte
    if (end_i && phase_d != PhFinished) begin
      res_vld_o = 1'b1;
      res_o     = '0;
      res_o.kind = pnmd_pkg::KindError;
      res_o.err  = pnmd_pkg::ErrTrunc;
      phase_d    = PhFinished;
    end

    res_o.width    = width_d;
    res_o.height   = height_d;
    res_o.is_color = color_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhMagic;
      tok_q     <= '0;
      started_q <= 1'b0;
      magic_q   <= '0;
      cmt_q     <= 1'b0;
      raw_q     <= 1'b0;
      color_q   <= 1'b0;
      width_q   <= '0;
      height_q  <= '0;
      col_q     <= '0;
      row_q     <= '0;
      chan_q    <= '0;
      held_q    <= '0;
    end else if (step_i) begin
      if (end_i) begin
        phase_q   <= PhMagic;
        tok_q     <= '0;
        started_q <= 1'b0;
        magic_q   <= '0;
        cmt_q     <= 1'b0;
        raw_q     <= 1'b0;
        color_q   <= 1'b0;
        width_q   <= '0;
        height_q  <= '0;
        col_q     <= '0;
        row_q     <= '0;
        chan_q    <= '0;
        held_q    <= '0;
      end else begin
        phase_q   <= phase_d;
        tok_q     <= tok_d;
        started_q <= started_d;
        magic_q   <= magic_d;
        cmt_q     <= cmt_d;
        raw_q     <= raw_d;
        color_q   <= color_d;
        width_q   <= width_d;
        height_q  <= height_d;
        col_q     <= col_d;
        row_q     <= row_d;
        chan_q    <= chan_d;
        held_q    <= held_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pnm_stream_decoder.sv =====
// A byte beat accepted into the input register is parsed and its result beat is
// captured in the result register, which drives m_axis. Throughput: one byte per
// cycle; the combinational parse stage between the two registers sets that rate,
// and stalls only while a result waits unread.
// Reset (rst_ni low, asynchronous) returns the parser to expecting the magic token;
// a beat with tlast does the same after its own result.
// Top level of the PNM stream decoder; instantiates pnmd_parser, uses pnmd_pkg.
`default_nettype none

module pnm_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  wire logic        s_axis_tlast,   // stream_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [pnmd_pkg::DataBits-1:0] m_axis_tdata,
  // [7:0] red, [15:8] green, [23:16] blue, [39:24] pixel_x, [55:40] pixel_y,
  // [71:56] image_width, [87:72] image_height, [88] is_color, [91:89] error_code
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  output logic             m_axis_tlast    // last_pixel
);

  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            in_end_q;
  logic            out_vld_q;
  pnmd_pkg::res_t  out_res_q;
  logic            advance;
  logic            res_vld;
  pnmd_pkg::res_t  res;

  pnmd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .end_i     (in_end_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready || !res_vld);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tlast  = out_res_q.last;
  assign m_axis_tdata  = {4'b0000, out_res_q.err, out_res_q.is_color,
                          out_res_q.height, out_res_q.width,
                          out_res_q.y, out_res_q.x,
                          out_res_q.blue, out_res_q.green, out_res_q.red};

endmodule

`default_nettype wire

// ===== rtl/pnmd_checker.sv =====
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on pnmd_pkg and pnm_stream_decoder.
`default_nettype none

module pnmd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [pnmd_pkg::DataBits-1:0] m_axis_tdata,
  input wire logic [1:0]                    m_axis_tuser,
  input wire logic                          m_axis_tlast
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == pnmd_pkg::KindPixel)
    else $error("tlast on a non-pixel beat");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser == pnmd_pkg::KindError) ==
       (m_axis_tdata[pnmd_pkg::ErrLsb +: 3] != pnmd_pkg::ErrNone)))
    else $error("error code does not match result kind");

endmodule

bind pnm_stream_decoder pnmd_checker u_pnmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
